/* sv/ppid_pkg.sv */
// Shared constants, types and term clamping for the positional PID block.
package ppid_pkg;

  localparam int DataWidth    = 32;
  localparam int AccWidth     = 48;
  localparam int GainWidth    = 32;
  localparam int LimitWidth   = 31;
  localparam int FracBits     = 16;
  localparam int ApbDataWidth = 32;
  localparam int RegCount     = 7;
  localparam int AddrWidth    = $clog2(RegCount) + 2;

  // integral magnitude is split in two halves for the partial products
  localparam int AccLoWidth = AccWidth / 2;
  localparam int AccHiWidth = AccWidth - AccLoWidth;

  // widest unsigned product of a magnitude and a gain magnitude
  localparam int ProdWidth = ((AccWidth > DataWidth) ? AccWidth : DataWidth + 1) + GainWidth;

  typedef enum logic [AddrWidth-3:0] {
    RegGainP    = 3'd0,
    RegGainI    = 3'd1,
    RegGainD    = 3'd2,
    RegPLimit   = 3'd3,
    RegILimit   = 3'd4,
    RegDLimit   = 3'd5,
    RegOutLimit = 3'd6
  } reg_idx_t;

  typedef logic signed [DataWidth-1:0]  data_t;
  typedef logic signed [AccWidth-1:0]   acc_t;
  typedef logic signed [GainWidth-1:0]  gain_t;
  typedef logic        [LimitWidth-1:0] limit_t;
  typedef logic signed [LimitWidth:0]   term_t;
  typedef logic        [ProdWidth-1:0]  prod_t;

  // floor(+/-prod / 2^FracBits), magnitude clamped to limit
  function automatic term_t clamp_term(input prod_t prod, input logic neg, input limit_t limit);
    logic [ProdWidth:0]          adj;
    logic [ProdWidth-FracBits:0] q;
    limit_t                      mq;
    term_t                       t;
    adj = {1'b0, prod} + (neg ? (ProdWidth+1)'((1 << FracBits) - 1) : '0);
    q   = adj[ProdWidth:FracBits];
    if (q > (ProdWidth-FracBits+1)'(limit)) begin
      mq = limit;
    end else begin
      mq = q[LimitWidth-1:0];
    end
    t = {1'b0, mq};
    return neg ? -t : t;
  endfunction

endpackage

/* sv/ppid_if.sv */
// Request channel interfaces: sample in, drive result out.
interface ppid_sample_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  ppid_pkg::data_t       setpoint;
  ppid_pkg::data_t       measured;
  modport source (output valid, func, setpoint, measured, input ready);
  modport sink   (input valid, func, setpoint, measured, output ready);
endinterface

interface ppid_result_if;
  logic                  valid;
  logic                  ready;
  ppid_pkg::data_t       drive;
  logic                  out_clamped;
  modport source (output valid, drive, out_clamped, input ready);
  modport sink   (input valid, drive, out_clamped, output ready);
endinterface

/* sv/positional_pid_term_clamped.sv */
// Positional PID with per-term and output clamping, signed Q16.16, pipelined.
//
//  channel   dir   handshake        payload
//  -------   ---   -------------    ------------------------------------
//  sample    in    valid / ready    func, setpoint, measured
//  result    out   valid / ready    drive, out_clamped
//  apb       in    psel / penable   paddr, pwdata (write), prdata (read)
//
// One request enters per cycle while sample.ready is high; each result passes the registers in turn
// (input reg -> error/state -> products -> terms -> output reg).
// The 48 x 32 integral product is split into two 24 x 32 halves, recombined a stage later.
// Each stage moves when it is empty or the stage after it moves, so bubbles close up
// behind a stalled result and sample.ready drops only when every stage is full.
// rst is synchronous: clears stage valids, error history, running sum, gains and limits.
module positional_pid_term_clamped (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppid_pkg::AddrWidth-1:0]   paddr,
  input  logic [ppid_pkg::ApbDataWidth-1:0] pwdata,
  output logic [ppid_pkg::ApbDataWidth-1:0] prdata,
  output logic                             pready,
  ppid_sample_if.sink                      sample,
  ppid_result_if.source                    result
);

  localparam int DW  = ppid_pkg::DataWidth;
  localparam int AW  = ppid_pkg::AccWidth;
  localparam int GW  = ppid_pkg::GainWidth;
  localparam int LW  = ppid_pkg::LimitWidth;
  localparam int PW  = ppid_pkg::ProdWidth;
  localparam int ALW = ppid_pkg::AccLoWidth;
  localparam int AHW = ppid_pkg::AccHiWidth;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  ppid_pkg::gain_t  gain_p, gain_i, gain_d;
  ppid_pkg::limit_t p_limit, i_limit, d_limit, out_limit;

  logic               cfg_write;
  ppid_pkg::reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = ppid_pkg::reg_idx_t'(paddr[ppid_pkg::AddrWidth-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      p_limit   <= '0;
      i_limit   <= '0;
      d_limit   <= '0;
      out_limit <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        ppid_pkg::RegGainP:    gain_p    <= pwdata[GW-1:0];
        ppid_pkg::RegGainI:    gain_i    <= pwdata[GW-1:0];
        ppid_pkg::RegGainD:    gain_d    <= pwdata[GW-1:0];
        ppid_pkg::RegPLimit:   p_limit   <= pwdata[LW-1:0];
        ppid_pkg::RegILimit:   i_limit   <= pwdata[LW-1:0];
        ppid_pkg::RegDLimit:   d_limit   <= pwdata[LW-1:0];
        ppid_pkg::RegOutLimit: out_limit <= pwdata[LW-1:0];
        default: ;  // unmapped address: write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ppid_pkg::RegGainP:    prdata = ppid_pkg::ApbDataWidth'(unsigned'(gain_p));
      ppid_pkg::RegGainI:    prdata = ppid_pkg::ApbDataWidth'(unsigned'(gain_i));
      ppid_pkg::RegGainD:    prdata = ppid_pkg::ApbDataWidth'(unsigned'(gain_d));
      ppid_pkg::RegPLimit:   prdata = ppid_pkg::ApbDataWidth'(p_limit);
      ppid_pkg::RegILimit:   prdata = ppid_pkg::ApbDataWidth'(i_limit);
      ppid_pkg::RegDLimit:   prdata = ppid_pkg::ApbDataWidth'(d_limit);
      ppid_pkg::RegOutLimit: prdata = ppid_pkg::ApbDataWidth'(out_limit);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4, out_valid;
  logic en1, en2, en3, en4, en_out;

  assign en_out       = !out_valid || result.ready;
  assign en4          = !v4 || en_out;
  assign en3          = !v3 || en4;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign sample.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= sample.valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en_out) out_valid <= v4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic            func1;
  ppid_pkg::data_t sp1, ms1;

  always_ff @(posedge clk) begin
    if (en1 && sample.valid) begin
      func1 <= sample.func;
      sp1   <= sample.setpoint;
      ms1   <= sample.measured;
    end
  end

  // error, saturated running sum and error difference; state moves with the item
  ppid_pkg::data_t        last_error;
  ppid_pkg::acc_t         error_sum;
  logic signed [DW:0]     err_raw;
  ppid_pkg::data_t        err;
  logic signed [AW:0]     sum_raw;
  ppid_pkg::acc_t         sum_next;
  logic signed [DW:0]     dif;

  always_comb begin
    if (func1) begin
      err_raw = {sp1[DW-1], sp1};
    end else begin
      err_raw = {sp1[DW-1], sp1} - {ms1[DW-1], ms1};
    end
    if (err_raw[DW] != err_raw[DW-1]) begin
      err = err_raw[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      err = err_raw[DW-1:0];
    end

    sum_raw = {error_sum[AW-1], error_sum} + {{(AW+1-DW){err[DW-1]}}, err};
    if (sum_raw[AW] != sum_raw[AW-1]) begin
      sum_next = sum_raw[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sum_next = sum_raw[AW-1:0];
    end

    dif = {err[DW-1], err} - {last_error[DW-1], last_error};
  end

  ppid_pkg::data_t    err2;
  ppid_pkg::acc_t     sum2;
  logic signed [DW:0] dif2;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (en2 && v1) begin
      last_error <= err;
      error_sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      err2 <= err;
      sum2 <= sum_next;
      dif2 <= dif;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sign/magnitude split and multipliers
  // ---------------------------------------------------------------------------
  logic [DW-1:0] mag_err;
  logic [AW-1:0] mag_sum;
  logic [DW:0]   mag_dif;
  logic [GW-1:0] mag_gp, mag_gi, mag_gd;

  always_comb begin
    mag_err = err2[DW-1]   ? -err2   : err2;
    mag_sum = sum2[AW-1]   ? -sum2   : sum2;
    mag_dif = dif2[DW]     ? -dif2   : dif2;
    mag_gp  = gain_p[GW-1] ? -gain_p : gain_p;
    mag_gi  = gain_i[GW-1] ? -gain_i : gain_i;
    mag_gd  = gain_d[GW-1] ? -gain_d : gain_d;
  end

  logic [DW+GW-1:0]  prod_p3;
  logic [DW+GW:0]    prod_d3;
  logic [ALW+GW-1:0] prod_ilo3;
  logic [AHW+GW-1:0] prod_ihi3;
  logic              neg_p3, neg_i3, neg_d3;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      prod_p3   <= (DW+GW)'(mag_err) * (DW+GW)'(mag_gp);
      prod_d3   <= (DW+GW+1)'(mag_dif) * (DW+GW+1)'(mag_gd);
      prod_ilo3 <= (ALW+GW)'(mag_sum[ALW-1:0]) * (ALW+GW)'(mag_gi);
      prod_ihi3 <= (AHW+GW)'(mag_sum[AW-1:ALW]) * (AHW+GW)'(mag_gi);
      neg_p3    <= err2[DW-1] ^ gain_p[GW-1];
      neg_i3    <= sum2[AW-1] ^ gain_i[GW-1];
      neg_d3    <= dif2[DW]   ^ gain_d[GW-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: recombine integral product, scale and clamp each term
  // ---------------------------------------------------------------------------
  ppid_pkg::prod_t prod_i;
  ppid_pkg::term_t pt, it, dt;

  always_comb begin
    prod_i = (PW'(prod_ihi3) << ALW) + PW'(prod_ilo3);
    pt     = ppid_pkg::clamp_term(PW'(prod_p3), neg_p3, p_limit);
    it     = ppid_pkg::clamp_term(prod_i, neg_i3, i_limit);
    dt     = ppid_pkg::clamp_term(PW'(prod_d3), neg_d3, d_limit);
  end

  ppid_pkg::term_t pt4, it4, dt4;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      pt4 <= pt;
      it4 <= it;
      dt4 <= dt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: term sum and output clamp
  // ---------------------------------------------------------------------------
  logic signed [LW+2:0] tsum, lim_pos, lim_neg;
  ppid_pkg::data_t      drive_next;
  logic                 clamp_next;

  always_comb begin
    tsum    = {{2{pt4[LW]}}, pt4} + {{2{it4[LW]}}, it4} + {{2{dt4[LW]}}, dt4};
    lim_pos = {3'b000, out_limit};
    lim_neg = -lim_pos;
    if (tsum > lim_pos) begin
      drive_next = DW'(lim_pos);
      clamp_next = 1'b1;
    end else if (tsum < lim_neg) begin
      drive_next = DW'(lim_neg);
      clamp_next = 1'b1;
    end else begin
      drive_next = DW'(tsum);
      clamp_next = 1'b0;
    end
  end

  ppid_pkg::data_t drive_q;
  logic            clamp_q;

  always_ff @(posedge clk) begin
    if (en_out && v4) begin
      drive_q <= drive_next;
      clamp_q <= clamp_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.drive       = drive_q;
  assign result.out_clamped = clamp_q;

endmodule

/* sv/ppid_checker.sv */
// Port-level assertions for the positional PID block, bound to the top level.
module ppid_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [ppid_pkg::AddrWidth-1:0]    paddr,
  input logic [ppid_pkg::ApbDataWidth-1:0] pwdata,
  input logic                              res_valid,
  input logic                              res_ready,
  input ppid_pkg::data_t                   drive,
  input logic                              out_clamped
);

  localparam int DW = ppid_pkg::DataWidth;
  localparam int LW = ppid_pkg::LimitWidth;

  // copy of the output limit as written over the bus
  ppid_pkg::limit_t   lim_seen;
  logic signed [DW:0] drive_x, lim_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_seen <= '0;
    end else if (psel && penable && pwrite &&
                 ppid_pkg::reg_idx_t'(paddr[ppid_pkg::AddrWidth-1:2]) ==
                 ppid_pkg::RegOutLimit) begin
      lim_seen <= pwdata[LW-1:0];
    end
  end

  assign drive_x = {drive[DW-1], drive};
  assign lim_x   = (DW+1)'(lim_seen);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(drive) && $stable(out_clamped))
    else $error("stalled result changed");

  a_drive_in_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> drive_x <= lim_x && drive_x >= -lim_x)
    else $error("drive outside output limit");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_clamped |-> drive_x == lim_x || drive_x == -lim_x)
    else $error("clamp flag set but drive not at limit");

endmodule

bind positional_pid_term_clamped ppid_checker u_ppid_checker (
  .clk         (clk),
  .rst         (rst),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .drive       (result.drive),
  .out_clamped (result.out_clamped)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the positional PID block: presets, integral ramp, random runs.
module tb_top;
  import ppid_pkg::*;

  // Handshake pacing and run shape
  localparam int IdlePct      = 28;      // chance per cycle that a side sits out
  localparam int StallLimit   = 4000;    // cycles with no handshake before giving up
  localparam int TailCycles   = 20;      // quiet time after the last result
  localparam int RandomPhases = 6;
  localparam int PhaseItems   = 205;
  localparam int DrainOdds    = 150;     // one in this many random requests waits for all results
  localparam int RegStride    = 4;       // byte step between registers
  localparam int UnmappedReg  = RegCount; // first index past the register map

  // Integral ramp: +full scale pushes the sum up, -full scale swings it well below zero,
  // then +full scale brings it back up.
  localparam int RailFill     = 60;
  localparam int RailSwing    = 90;
  localparam int RailReturn   = 50;

  // Register presets; values are in register index order
  typedef logic [2:0] set_id_t;
  localparam set_id_t SetReset    = 3'd0;
  localparam set_id_t SetNoOut    = 3'd1;
  localparam set_id_t SetPOnly    = 3'd2;
  localparam set_id_t SetDOnly    = 3'd3;
  localparam set_id_t SetExtreme  = 3'd4;
  localparam set_id_t SetModerate = 3'd5;
  localparam set_id_t SetIntegral = 3'd6;
  localparam int PresetCount  = 7;
  localparam int DirectedRows = 23;

  localparam data_t DataMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t DataMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam data_t Zero    = '0;

  typedef struct packed {
    data_t drive;
    logic  clamped;
  } drive_res_t;

  // One directed request; typed rows carry the drive result read straight off the spec
  typedef struct packed {
    set_id_t    set_id;
    logic       func;
    data_t      sp;
    data_t      ms;
    logic       typed;
    data_t      drive;
    logic       clamped;
  } dir_row_t;

  typedef logic [ApbDataWidth-1:0] reg_set_t [RegCount];

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [AddrWidth-1:0]    paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  ppid_sample_if sample_ch ();
  ppid_result_if result_ch ();

  positional_pid_term_clamped dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  // Shadow of the block: register file (gains sign-extended, limits 31 bit) and loop state
  longint     cfg_val [RegCount];
  longint     last_err;
  longint     err_sum;
  drive_res_t pending_drives [$];

  reg_set_t   presets [PresetCount];
  reg_set_t   next_set;
  dir_row_t   directed_rows [DirectedRows];

  bit         steady;          // suppresses idling on both sides
  int         fail_count;
  int         samples_sent;
  int         results_seen;
  int         clamp_hits;
  int         reg_writes;
  int         stall_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Drive prediction
  // ------------------------------------------------------------------

  // floor(x * gain / 2^16), clamped to +/- lim; the product is exact at 128 bits
  function automatic longint gain_term(longint x, longint gain, longint lim);
    logic signed [127:0] wx;
    logic signed [127:0] wg;
    logic signed [127:0] prod;
    wx   = x;
    wg   = gain;
    prod = (wx * wg) >>> FracBits;
    if (prod > lim) return lim;
    if (prod < -lim) return -lim;
    return longint'(prod);
  endfunction

  // Advances the shadow loop state by one sample and returns its drive result
  function automatic drive_res_t predict_drive(logic f, data_t sp, data_t ms);
    longint     dmax;
    longint     amax;
    longint     amin;
    longint     err;
    longint     p_t;
    longint     i_t;
    longint     d_t;
    longint     total;
    longint     lim;
    drive_res_t res;
    dmax = (longint'(1) <<< (DataWidth - 1)) - 1;
    amax = (longint'(1) <<< (AccWidth - 1)) - 1;
    amin = -amax - 1;

    // error saturates at the data width (only reachable with func 0)
    err = f ? longint'(sp) : longint'(sp) - longint'(ms);
    if (err > dmax) err = dmax;
    else if (err < -dmax - 1) err = -dmax - 1;

    // running sum sticks at the accumulator rails
    if (err > 0 && err_sum > amax - err) err_sum = amax;
    else if (err < 0 && err_sum < amin - err) err_sum = amin;
    else err_sum += err;

    p_t = gain_term(err, cfg_val[RegGainP], cfg_val[RegPLimit]);
    i_t = gain_term(err_sum, cfg_val[RegGainI], cfg_val[RegILimit]);
    d_t = gain_term(err - last_err, cfg_val[RegGainD], cfg_val[RegDLimit]);

    // landing exactly on the output limit does not count as clamped
    total       = p_t + i_t + d_t;
    lim         = cfg_val[RegOutLimit];
    res.clamped = 1'b0;
    if (total > lim) begin
      total       = lim;
      res.clamped = 1'b1;
    end else if (total < -lim) begin
      total       = -lim;
      res.clamped = 1'b1;
    end
    res.drive = data_t'(total);
    last_err  = err;
    return res;
  endfunction

  // Register write as the block sees it; indexes past the map change nothing
  function automatic void store_reg(int idx, logic [ApbDataWidth-1:0] value);
    if (idx < RegCount) begin
      case (reg_idx_t'(idx))
        RegGainP, RegGainI, RegGainD: cfg_val[idx] = longint'($signed(value));
        default:                      cfg_val[idx] = longint'(value[LimitWidth-1:0]);
      endcase
    end
  endfunction

  // ------------------------------------------------------------------
  // Random values
  // ------------------------------------------------------------------

  // Mix of rails, zero, small signed values and full-range noise
  function automatic data_t rand_data();
    int v;
    v = $urandom_range(0, 2097152) - 1048576;
    case ($urandom_range(0, 9))
      0:       return DataMax;
      1:       return DataMin;
      2:       return Zero;
      3, 4, 5: return data_t'(v);
      default: return data_t'($urandom());
    endcase
  endfunction

  function automatic logic [ApbDataWidth-1:0] rand_reg_value(int idx);
    int v;
    v = $urandom_range(0, 524288) - 262144;
    case (reg_idx_t'(idx))
      RegGainP, RegGainI, RegGainD: begin
        case ($urandom_range(0, 7))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '0;
          3, 4, 5: return 32'(v);
          default: return $urandom();
        endcase
      end
      default: begin
        // bit 31 is random throughout: the register keeps only 31 bits
        case ($urandom_range(0, 5))
          0:       return {1'($urandom()), 31'h0};
          1:       return {1'($urandom()), 31'h7FFF_FFFF};
          2, 3:    return {1'($urandom()), 31'($urandom_range(0, 33554432))};
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Register port
  // ------------------------------------------------------------------

  // psel stays high between back-to-back accesses; load_settings drops it at the end
  task automatic reg_write(input int idx, input logic [ApbDataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'(idx * RegStride);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    store_reg(idx, value);
    reg_writes++;
  endtask

  task automatic reg_check(input int idx);
    logic [ApbDataWidth-1:0] want;
    want    = ApbDataWidth'(cfg_val[idx]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrWidth'(idx * RegStride);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata (reg %0d): expected %h, got %h", idx, want, prdata);
      fail_count++;
    end
  endtask

  // Writes every register, pokes the unmapped slot, then reads all back.
  // Only called with the pipeline empty.
  task automatic load_settings(input reg_set_t vals);
    for (int i = 0; i < RegCount; i++) reg_write(i, vals[i]);
    reg_write(UnmappedReg, $urandom());
    for (int i = 0; i < RegCount; i++) reg_check(i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Sample requests
  // ------------------------------------------------------------------

  // Optional idle cycles, then one request held until taken; the expected drive
  // is pushed at the edge that takes it.
  task automatic send_sample(input logic f, input data_t sp, input data_t ms,
                             input logic typed, input drive_res_t typed_res);
    drive_res_t pred;
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.func     <= f;
    sample_ch.setpoint <= sp;
    sample_ch.measured <= ms;
    do @(posedge clk); while (!sample_ch.ready);
    pred = predict_drive(f, sp, ms);
    pending_drives.push_back(typed ? typed_res : pred);
    samples_sent++;
  endtask

  // Stop sending and wait for every outstanding drive result.
  // Each sample yields a result, so an empty queue means an idle pipeline.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_drives.size() != 0);
  endtask

  // ------------------------------------------------------------------
  // Result side: random backpressure and checking
  // ------------------------------------------------------------------

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    drive_res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (result_ch.out_clamped === 1'b1) clamp_hits++;
      if (pending_drives.size() == 0) begin
        $error("drive result with none outstanding: drive %0d, out_clamped %0b",
               result_ch.drive, result_ch.out_clamped);
        fail_count++;
      end else begin
        want = pending_drives.pop_front();
        if (result_ch.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, result_ch.drive);
          fail_count++;
        end
        if (result_ch.out_clamped !== want.clamped) begin
          $error("out_clamped: expected %0b, got %0b", want.clamped, result_ch.out_clamped);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on either channel or the register port counts as progress
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  initial begin
    set_id_t cur_set;
    data_t sp;
    data_t ms;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.func     <= 1'b0;
    sample_ch.setpoint <= '0;
    sample_ch.measured <= '0;
    steady       = 1'b0;
    fail_count   = 0;
    samples_sent = 0;
    results_seen = 0;
    clamp_hits   = 0;
    reg_writes   = 0;
    last_err     = 0;
    err_sum      = 0;
    for (int i = 0; i < RegCount; i++) cfg_val[i] = 0;

    // gain_p, gain_i, gain_d, p_limit, i_limit, d_limit, out_limit
    presets[SetReset]    = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    // every term live but the output limit at zero: drive pinned to 0
    presets[SetNoOut]    = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0};
    // P alone at unity gain against a 1.0 output limit: drive is the clamped error
    presets[SetPOnly]    = '{32'h0001_0000, 32'h0, 32'h0,
                             32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000};
    // P and I gains live but their limits at zero; only D reaches the output
    presets[SetDOnly]    = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                             32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    // rail gains; limits written all-ones so bit 31 must be dropped
    presets[SetExtreme]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    presets[SetModerate] = '{32'h0001_8000, 32'h0000_0800, 32'hFFFF_0000,
                             32'h0100_0000, 32'h0080_0000, 32'h0200_0000, 32'h0180_0000};
    // smallest integral gain: I is the sum scaled down, so the ramp shows at the output
    presets[SetIntegral] = '{32'h0, 32'h0000_0001, 32'h0,
                             32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF};

    // set, func, setpoint, measured, typed, drive, out_clamped
    directed_rows = '{
      // out of reset every gain and limit is zero
      '{SetReset,    1'b0, DataMax,        DataMin,        1'b1, Zero, 1'b0}, // error tops out
      '{SetReset,    1'b0, DataMin,        DataMax,        1'b1, Zero, 1'b0}, // error bottoms out
      '{SetReset,    1'b1, DataMin,        DataMax,        1'b1, Zero, 1'b0},
      '{SetReset,    1'b1, DataMax,        Zero,           1'b1, Zero, 1'b0},
      // zero output limit
      '{SetNoOut,    1'b1, 32'sh0003_0000, Zero,           1'b0, Zero, 1'b0},
      '{SetNoOut,    1'b0, Zero,           32'sh0001_0000, 1'b0, Zero, 1'b0},
      // around the output limit: equal is not clamped, one lsb past is
      '{SetPOnly,    1'b1, 32'sh0001_0000, Zero,           1'b0, Zero, 1'b0},
      '{SetPOnly,    1'b1, 32'sh0001_0001, Zero,           1'b0, Zero, 1'b0},
      '{SetPOnly,    1'b1, 32'shFFFF_0000, Zero,           1'b0, Zero, 1'b0},
      '{SetPOnly,    1'b1, 32'shFFFE_FFFF, Zero,           1'b0, Zero, 1'b0},
      '{SetPOnly,    1'b0, 32'sh0000_8000, 32'sh0000_8000, 1'b0, Zero, 1'b0},
      // zero term limits
      '{SetDOnly,    1'b1, 32'sh0002_0000, Zero,           1'b0, Zero, 1'b0},
      '{SetDOnly,    1'b1, 32'shFFFE_0000, Zero,           1'b0, Zero, 1'b0},
      '{SetDOnly,    1'b0, DataMax,        DataMin,        1'b0, Zero, 1'b0},
      // rail gains against rail errors; widest D step is a full 33-bit swing
      '{SetExtreme,  1'b1, DataMax,        Zero,           1'b0, Zero, 1'b0},
      '{SetExtreme,  1'b1, DataMin,        Zero,           1'b0, Zero, 1'b0},
      '{SetExtreme,  1'b0, DataMin,        DataMax,        1'b0, Zero, 1'b0},
      '{SetExtreme,  1'b0, 32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, Zero, 1'b0},
      '{SetExtreme,  1'b1, 32'shFFFF_FFFF, Zero,           1'b0, Zero, 1'b0}, // floor of -lsb
      '{SetModerate, 1'b0, 32'sh0005_0000, 32'sh0002_0000, 1'b0, Zero, 1'b0},
      '{SetModerate, 1'b0, 32'shFFF0_0000, 32'sh0010_0000, 1'b0, Zero, 1'b0},
      '{SetModerate, 1'b1, 32'sh7FFF_0000, DataMin,        1'b0, Zero, 1'b0},
      '{SetModerate, 1'b1, 32'sh0000_0003, DataMax,        1'b0, Zero, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table; a change of preset waits for the pipeline to empty first
    cur_set = SetReset;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_id != cur_set) begin
        drain();
        cur_set = directed_rows[r].set_id;
        load_settings(presets[cur_set]);
      end
      send_sample(directed_rows[r].func, directed_rows[r].sp, directed_rows[r].ms,
                  directed_rows[r].typed,
                  '{drive: directed_rows[r].drive, clamped: directed_rows[r].clamped});
    end

    // Integral ramp, with no idling on either side for the whole walk
    drain();
    steady = 1'b1;
    load_settings(presets[SetIntegral]);
    for (int n = 0; n < RailFill; n++) send_sample(1'b1, DataMax, rand_data(), 1'b0, '0);
    for (int n = 0; n < RailSwing; n++) send_sample(1'b1, DataMin, rand_data(), 1'b0, '0);
    for (int n = 0; n < RailReturn; n++) send_sample(1'b1, DataMax, rand_data(), 1'b0, '0);
    drain();
    steady = 1'b0;

    // Random phases, each under freshly drawn register values
    for (int ph = 0; ph < RandomPhases; ph++) begin
      drain();
      for (int i = 0; i < RegCount; i++) next_set[i] = rand_reg_value(i);
      load_settings(next_set);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(1, DrainOdds) == 1) drain();
        sp = rand_data();
        // a quarter of the time measured tracks setpoint closely: small errors
        if ($urandom_range(0, 3) == 0) ms = sp + data_t'($urandom_range(0, 4096)) - 2048;
        else ms = rand_data();
        send_sample(1'($urandom()), sp, ms, 1'b0, '0);
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d samples and %0d drive results (%0d clamped), %0d register writes,",
             samples_sent, results_seen, clamp_hits, reg_writes);
    $display("presets at the limits, a full-scale integral ramp and %0d random register phases.",
             RandomPhases);
    if (fail_count == 0 && pending_drives.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
